// File: rtl/float_trig_argument_reduction_assert.svh
// Assertion macros for the pi/2 argument reduction block.
// Used by the top level; assertions drop out when SYNTH is defined.
`ifndef FLOAT_TRIG_ARGUMENT_REDUCTION_ASSERT_SVH
`define FLOAT_TRIG_ARGUMENT_REDUCTION_ASSERT_SVH
`ifndef SYNTH
`define FTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTA_ASSERT(lbl, prop, msg)
`define FTA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/fta_pkg.sv
// Shared types, constants and helper functions for the pi/2 reduction pipeline.
// No dependencies.
package fta_pkg;

  localparam int CHUNK_BITS      = 24;
  localparam int CHUNK_COUNT_DEF = 5;
  localparam int TABLE_WORDS_DEF = 16;
  localparam int F_W             = 10;  // fraction bit count, up to 24*5+149
  localparam int EV_W            = 12;  // signed exponent of intermediates
  localparam int IDX_W           = 4;   // chunk index, k + CHUNK_COUNT - 1 <= 11
  localparam int K_W             = 3;   // window index, at most 4
  localparam logic [7:0]  K_BASE_EXP = 8'd152;
  localparam logic [21:0] K_RECIP    = 22'h2aab;
  localparam int          K_SHIFT    = 18;
  localparam int          E_OFS      = 150;
  localparam logic [63:0] PIO2_Q63   = 64'hC90FDAA22168C235;
  localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;

  // per-item flags carried along the pipe
  typedef struct packed {
    logic       sgn;   // input sign
    logic       nan;   // infinity or NaN input
    logic       fz;    // fraction is zero after rounding
    logic       rsgn;  // sign of reduced angle
    logic [1:0] q;     // quadrant
  } side_t;

  typedef struct packed {
    logic [31:0] bits;
    logic [63:0] rem;
    logic        rem_sgn;
  } ts_res_t;

  // leading chunks of 2/pi, 24 bits each
  function automatic logic [CHUNK_BITS-1:0] chunk_at(input logic [IDX_W-1:0] idx);
    logic [CHUNK_BITS-1:0] c;
    unique case (idx)
      4'd0:  c = 24'ha2f983;
      4'd1:  c = 24'h6e4e44;
      4'd2:  c = 24'h1529fc;
      4'd3:  c = 24'h2757d1;
      4'd4:  c = 24'hf534dd;
      4'd5:  c = 24'hc0db62;
      4'd6:  c = 24'h95993c;
      4'd7:  c = 24'h439041;
      4'd8:  c = 24'hfe5163;
      4'd9:  c = 24'habdebb;
      4'd10: c = 24'hc561b7;
      4'd11: c = 24'h246e3a;
      4'd12: c = 24'h424dd2;
      4'd13: c = 24'he00649;
      4'd14: c = 24'h2eea09;
      4'd15: c = 24'hd1921c;
      default: c = '0;
    endcase
    return c;
  endfunction

  // leading zero count of a 64-bit word (63 for zero)
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd63;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

  // round mag * 2^ex (mag[63] set) to single, nearest even, with subnormals
  function automatic ts_res_t to_single(input logic sgn, input logic [63:0] mag,
                                        input logic signed [EV_W-1:0] ex);
    logic signed [EV_W+1:0] b;
    logic signed [EV_W+1:0] s;
    logic [5:0]  sh;
    logic [63:0] half;
    logic [63:0] low;
    logic [63:0] r;
    logic        up;
    ts_res_t     o;
    b    = (EV_W+2)'(ex) + 14'sd190;
    s    = (b >= 14'sd1) ? 14'sd40 : 14'sd41 - b;
    sh   = s[5:0];
    up   = 1'b0;
    r    = '0;
    half = '0;
    low  = '0;
    o.rem = mag;
    if (s > 14'sd64) begin
      o.rem = mag;
    end else if (s == 14'sd64) begin
      if (mag > 64'h8000000000000000) begin
        r     = 64'd1;
        up    = 1'b1;
        o.rem = 64'd0 - mag;
      end
    end else begin
      half = 64'd1 << (sh - 6'd1);
      low  = mag & ((half << 1) - 64'd1);
      r    = mag >> sh;
      if (low > half || (low == half && r[0])) up = 1'b1;
      if (up) begin
        r     = r + 64'd1;
        o.rem = (half << 1) - low;
      end else begin
        o.rem = low;
      end
    end
    o.rem_sgn = sgn ^ up;
    if (b >= 14'sd1) o.bits = {sgn, (31'(b - 14'sd1) << 23) + r[30:0]};
    else o.bits = {sgn, r[30:0]};
    return o;
  endfunction

endpackage

// File: rtl/float_trig_argument_reduction.sv
// Top level of the single-precision pi/2 argument reduction pipeline.
// Depends on fta_pkg, fta_window, fta_reduce, fta_scale and the assert header.
//
//  channel  | dir | payload
//  in_*     | in  | tdata[31:0] = x_bits
//  out_*    | out | tdata[1:0] = quadrant, [33:2] = rem_hi, [65:34] = rem_lo
//
// Eleven register stages; one operand per clock unless the output stalls.
// The pi/2 multiply (four 32x32 partials) and the chunk products set the depth.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// A stall at the output freezes the whole pipe; in_tready follows it.
`include "float_trig_argument_reduction_assert.svh"
module float_trig_argument_reduction import fta_pkg::*; #(
  parameter int CHUNK_COUNT = CHUNK_COUNT_DEF,
  parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // quadrant[1:0], rem_hi[33:2], rem_lo[65:34], zero pad
);

  localparam int NB = (CHUNK_COUNT + 1) * CHUNK_BITS;

  logic          en;
  logic          w_valid, r_valid;
  logic [NB-1:0] w_p;
  logic [F_W-1:0] w_f;
  side_t         w_side, r_side;
  logic [63:0]   r_mv;
  logic signed [EV_W-1:0] r_ev;
  logic [1:0]    quadrant;
  logic [31:0]   rem_hi, rem_lo;

  // whole pipe advances unless a result waits unaccepted
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  fta_window #(.CHUNK_COUNT(CHUNK_COUNT), .TABLE_WORDS(TABLE_WORDS)) u_window (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .x_bits(in_tdata),
    .out_valid(w_valid), .out_p(w_p), .out_f(w_f), .out_side(w_side)
  );

  fta_reduce #(.CHUNK_COUNT(CHUNK_COUNT)) u_reduce (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(w_valid), .in_p(w_p), .in_f(w_f),
    .in_side(w_side), .out_valid(r_valid), .out_mv(r_mv), .out_ev(r_ev), .out_side(r_side)
  );

  fta_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r_valid), .in_mv(r_mv), .in_ev(r_ev),
    .in_side(r_side), .out_valid(out_tvalid), .out_quadrant(quadrant),
    .out_rem_hi(rem_hi), .out_rem_lo(rem_lo)
  );

  assign out_tdata = {6'd0, rem_lo, rem_hi, quadrant};

  // reduced angle stays below one in magnitude unless NaN
  `FTA_ASSERT(a_rem_small, out_tvalid && rem_hi[30:23] != 8'hFF |-> rem_hi[30:23] < 8'd127, "reduced angle out of range")
  // residual never larger in exponent than the high word
  `FTA_ASSERT(a_lo_below_hi, out_tvalid |-> rem_lo[30:23] <= rem_hi[30:23], "residual exponent exceeds high word")
  // a waiting result holds the input side off
  `FTA_ASSERT(a_stall_blocks, out_tvalid && !out_tready |-> !in_tready, "input taken during output stall")

endmodule

// File: rtl/fta_window.sv
// Stages 1-3: exponent decode, 2/pi window lookup, chunk products and their sum.
// Depends on fta_pkg.
module fta_window import fta_pkg::*; #(
  parameter int CHUNK_COUNT = CHUNK_COUNT_DEF,
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int NB = (CHUNK_COUNT + 1) * CHUNK_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   x_bits,
  output logic          out_valid,
  output logic [NB-1:0] out_p,
  output logic [F_W-1:0] out_f,
  output side_t         out_side
);

  logic [7:0]            e;
  logic [7:0]            eb;
  logic [21:0]           kp;
  logic [K_W-1:0]        k;
  logic [IDX_W-1:0]      idx [CHUNK_COUNT];
  logic [CHUNK_BITS-1:0] m_nxt;
  logic [F_W-1:0]        f_nxt;
  side_t                 side_nxt;
  logic [CHUNK_BITS-1:0] chunk_nxt [CHUNK_COUNT];
  logic [NB-1:0]         p_nxt;

  logic                  v1_r, v2_r, v3_r;
  logic [CHUNK_BITS-1:0] m1_r;
  logic [CHUNK_BITS-1:0] chunk1_r [CHUNK_COUNT];
  logic [2*CHUNK_BITS-1:0] pp2_r [CHUNK_COUNT];
  logic [F_W-1:0]        f1_r, f2_r, f3_r;
  side_t                 side1_r, side2_r, side3_r;
  logic [NB-1:0]         p3_r;

  // decode and window select
  always_comb begin
    e  = x_bits[30:23];
    eb = (e == 8'd0) ? 8'd1 : e;
    m_nxt = {(e != 8'd0), x_bits[22:0]};
    kp = 22'(e - K_BASE_EXP) * K_RECIP;
    k  = (e >= K_BASE_EXP) ? K_W'(kp >> K_SHIFT) : '0;
    f_nxt = F_W'(k) * F_W'(CHUNK_BITS) + F_W'(CHUNK_BITS * CHUNK_COUNT + E_OFS) - F_W'(eb);
    side_nxt = '{sgn: x_bits[31], nan: (e == 8'hFF), fz: 1'b0, rsgn: 1'b0, q: 2'd0};
    for (int j = 0; j < CHUNK_COUNT; j++) begin
      idx[j] = IDX_W'(k) + IDX_W'(j);
      chunk_nxt[j] = (int'(idx[j]) < TABLE_WORDS) ? chunk_at(idx[j]) : '0;
    end
  end

  // sum of shifted chunk products; chunk 0 is the most significant
  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < CHUNK_COUNT; j++) begin
      p_nxt = p_nxt + (NB'(pp2_r[j]) << (CHUNK_BITS * (CHUNK_COUNT - 1 - j)));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= m_nxt;
      f1_r    <= f_nxt;
      side1_r <= side_nxt;
      for (int j = 0; j < CHUNK_COUNT; j++) begin
        chunk1_r[j] <= chunk_nxt[j];
        pp2_r[j]    <= (2*CHUNK_BITS)'(m1_r) * (2*CHUNK_BITS)'(chunk1_r[j]);
      end
      f2_r    <= f1_r;
      side2_r <= side1_r;
      p3_r    <= p_nxt;
      f3_r    <= f2_r;
      side3_r <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_p     = p3_r;
  assign out_f     = f3_r;
  assign out_side  = side3_r;

endmodule

// File: rtl/fta_reduce.sv
// Stages 4-6: quadrant, nearest-integer rounding of the product, leading one
// search and normalization to 64 bits. Depends on fta_pkg.
module fta_reduce import fta_pkg::*; #(
  parameter int CHUNK_COUNT = CHUNK_COUNT_DEF,
  localparam int NB = (CHUNK_COUNT + 1) * CHUNK_BITS,
  localparam int HW = $clog2(NB)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NB-1:0]          in_p,
  input  logic [F_W-1:0]         in_f,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic [63:0]            out_mv,
  output logic signed [EV_W-1:0] out_ev,
  output side_t                  out_side
);

  logic [NB-1:0] mask;
  logic [NB-1:0] hbit;
  logic [NB-1:0] frac;
  logic [NB-1:0] frac_nxt;
  logic [1:0]    q0;
  logic [1:0]    q;
  logic          half;
  logic          sticky;
  logic          up;
  side_t         side4_nxt;
  side_t         side5_nxt;
  logic [HW-1:0] h_nxt;
  logic [NB-1:0] shifted;
  logic signed [EV_W-1:0] ev_nxt;

  logic          v4_r, v5_r, v6_r;
  logic [NB-1:0] frac4_r, frac5_r;
  logic [F_W-1:0] f4_r, f5_r;
  side_t         side4_r, side5_r, side6_r;
  logic [HW-1:0] h5_r;
  logic [63:0]   mv6_r;
  logic signed [EV_W-1:0] ev6_r;

  // round to nearest integer, ties to even; keep signed fraction magnitude
  always_comb begin
    mask   = ~({NB{1'b1}} << in_f);
    hbit   = NB'(1) << (in_f - F_W'(1));
    q0     = 2'(in_p >> in_f);
    frac   = in_p & mask;
    half   = |(in_p & hbit);
    sticky = |(in_p & (mask >> 1));
    up     = half & (sticky | q0[0]);
    frac_nxt = up ? ((~frac + NB'(1)) & mask) : frac;
    q = q0 + {1'b0, up};
    side4_nxt      = in_side;
    side4_nxt.q    = in_side.sgn ? (2'd0 - q) : q;
    side4_nxt.rsgn = in_side.sgn ^ up;
  end

  // leading one position; flag an all-zero fraction
  always_comb begin
    h_nxt = '0;
    for (int i = 0; i < NB; i++) begin
      if (frac4_r[i]) h_nxt = HW'(i);
    end
    side5_nxt    = side4_r;
    side5_nxt.fz = ~(|frac4_r);
  end

  // normalize so the leading one lands on the top bit
  always_comb begin
    shifted = frac5_r << (HW'(NB - 1) - h5_r);
    ev_nxt  = signed'(EV_W'(h5_r)) - signed'(EV_W'(f5_r)) - signed'(EV_W'(126));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac4_r <= frac_nxt;
      f4_r    <= in_f;
      side4_r <= side4_nxt;
      frac5_r <= frac4_r;
      f5_r    <= f4_r;
      h5_r    <= h_nxt;
      side5_r <= side5_nxt;
      mv6_r   <= shifted[NB-1 -: 64];
      ev6_r   <= ev_nxt;
      side6_r <= side5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_mv    = mv6_r;
  assign out_ev    = ev6_r;
  assign out_side  = side6_r;

endmodule

// File: rtl/fta_scale.sv
// Stages 7-11: multiply by pi/2, round to single high word, normalize the
// residual and round it to the low word. Depends on fta_pkg.
module fta_scale import fta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [63:0]            in_mv,
  input  logic signed [EV_W-1:0] in_ev,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic [1:0]             out_quadrant,
  output logic [31:0]            out_rem_hi,
  output logic [31:0]            out_rem_lo
);

  logic [127:0] prod;
  logic [63:0]  mv8_nxt;
  logic signed [EV_W-1:0] ev8_nxt;
  ts_res_t      hi_res;
  ts_res_t      lo_res;
  logic [5:0]   n;
  logic [1:0]   q_out;
  logic [31:0]  hi_out;
  logic [31:0]  lo_out;

  logic         v7_r, v8_r, v9_r, v10_r, v11_r;
  logic [63:0]  phh7_r, phl7_r, plh7_r, pll7_r;
  logic signed [EV_W-1:0] ev7_r, ev8_r, ev9_r, ev10_r;
  side_t        side7_r, side8_r, side9_r, side10_r;
  logic [63:0]  mv8_r;
  logic [31:0]  hi9_r, hi10_r;
  logic [63:0]  res9_r, res10_r;
  logic         dsg9_r, dsg10_r, rz10_r;
  logic [1:0]   q11_r;
  logic [31:0]  hi11_r, lo11_r;

  // assemble 128-bit product, take top 64 bits normalized
  always_comb begin
    prod = {phh7_r, 64'd0} + {32'd0, phl7_r, 32'd0} + {32'd0, plh7_r, 32'd0} + {64'd0, pll7_r};
    mv8_nxt = prod[127] ? prod[127:64] : prod[126:63];
    ev8_nxt = ev7_r + (prod[127] ? EV_W'(64) : EV_W'(63));
  end

  assign hi_res = to_single(side8_r.rsgn, mv8_r, ev8_r);
  assign n      = lzc64(res9_r);
  assign lo_res = to_single(dsg10_r, res10_r, ev10_r);

  // final selection for special cases
  always_comb begin
    q_out  = side10_r.q;
    hi_out = hi10_r;
    lo_out = rz10_r ? 32'd0 : lo_res.bits;
    if (side10_r.nan) begin
      q_out  = 2'd0;
      hi_out = QNAN_BITS;
      lo_out = QNAN_BITS;
    end else if (side10_r.fz) begin
      hi_out = 32'd0;
      lo_out = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else if (en) begin
      v7_r  <= in_valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phh7_r   <= {32'd0, in_mv[63:32]} * {32'd0, PIO2_Q63[63:32]};
      phl7_r   <= {32'd0, in_mv[63:32]} * {32'd0, PIO2_Q63[31:0]};
      plh7_r   <= {32'd0, in_mv[31:0]} * {32'd0, PIO2_Q63[63:32]};
      pll7_r   <= {32'd0, in_mv[31:0]} * {32'd0, PIO2_Q63[31:0]};
      ev7_r    <= in_ev;
      side7_r  <= in_side;
      mv8_r    <= mv8_nxt;
      ev8_r    <= ev8_nxt;
      side8_r  <= side7_r;
      hi9_r    <= hi_res.bits;
      res9_r   <= hi_res.rem;
      dsg9_r   <= hi_res.rem_sgn;
      ev9_r    <= ev8_r;
      side9_r  <= side8_r;
      hi10_r   <= hi9_r;
      res10_r  <= res9_r << n;
      ev10_r   <= ev9_r - EV_W'(n);
      rz10_r   <= (res9_r == 64'd0);
      dsg10_r  <= dsg9_r;
      side10_r <= side9_r;
      q11_r    <= q_out;
      hi11_r   <= hi_out;
      lo11_r   <= lo_out;
    end
  end

  assign out_valid    = v11_r;
  assign out_quadrant = q11_r;
  assign out_rem_hi   = hi11_r;
  assign out_rem_lo   = lo11_r;

endmodule
